// ===== hdl/ccfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera control frame parser package
// Shared types, protocol codes and the CRC8 (polynomial 0xD5) byte update used
// by the front end, the frame engine and the top level.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hCC;
  localparam logic [7:0] CRC_POLY  = 8'hD5;

  // Frame lengths in bytes, header and CRC included; zero marks an unknown command.
  localparam int unsigned LEN_W     = 3;
  localparam logic [2:0]  LEN_NONE  = 3'd0;
  localparam logic [2:0]  LEN_SHORT = 3'd3;
  localparam logic [2:0]  LEN_LONG  = 3'd4;

  // Byte positions inside a buffered frame.
  localparam int unsigned POS_CMD    = 1;
  localparam int unsigned POS_ACTION = 2;
  localparam int unsigned POS_CRC_S  = 2;
  localparam int unsigned POS_CRC_L  = 3;

  localparam logic [7:0] CMD_DEVICE_INFO   = 8'h00;
  localparam logic [7:0] CMD_CAMERA        = 8'h01;
  localparam logic [7:0] CMD_KEY_PRESS     = 8'h02;
  localparam logic [7:0] CMD_KEY_RELEASE   = 8'h03;
  localparam logic [7:0] CMD_KEY_HANDSHAKE = 8'h04;

  localparam logic [7:0] ACT_TOGGLE = 8'h01;
  localparam logic [7:0] ACT_START  = 8'h03;
  localparam logic [7:0] ACT_STOP   = 8'h04;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd0;
  localparam logic [1:0] REG_FEATURE_BITS     = 2'd1;
  localparam logic [1:0] REG_REPLY_ENABLE     = 2'd2;

  localparam logic [7:0]  VERSION_RESET      = 8'd1;
  localparam logic [15:0] FEATURE_RESET      = 16'd197;
  localparam logic        REPLY_ENABLE_RESET = 1'b1;

  // The device info reply is five bytes long.
  localparam logic [2:0] REPLY_LAST = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_TOGGLE,
    EV_START,
    EV_STOP
  } event_t;

  typedef enum logic {
    OP_BYTE,
    OP_IDLE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       is_sync;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [15:0] feature_bits;
    logic        reply_enable;
  } cfg_t;

  typedef struct packed {
    event_t      event_res;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        last;
    logic [15:0] frame_count;
    logic [15:0] crc_error_count;
    logic [15:0] resync_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRC,
    ST_CHECK,
    ST_DROP,
    ST_SEEK,
    ST_EMIT,
    ST_REPLY
  } state_t;

  function automatic logic [7:0] crc_update(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [2:0] length_for(input logic [7:0] cmd);
    logic [2:0] len;
    unique case (cmd) inside
      CMD_DEVICE_INFO, CMD_KEY_RELEASE:               len = LEN_SHORT;
      CMD_CAMERA, CMD_KEY_PRESS, CMD_KEY_HANDSHAKE:   len = LEN_LONG;
      default:                                        len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/ccfp_front.sv =====
// ----------------------------------------------------------------------------
// Camera control frame parser front end
// Accepts input items, classifies them as received bytes or line-idle events
// and holds them in a two-entry queue for the frame engine.
// ----------------------------------------------------------------------------
module ccfp_front
  import ccfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      slot [2];
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  item_t      item_in;

  assign in_stall = (fill == 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    item_in.op      = mode ? OP_IDLE : OP_BYTE;
    item_in.is_sync = !mode && (rx_byte == SYNC_BYTE);
    item_in.data    = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

endmodule

// ===== hdl/ccfp_back.sv =====
// ----------------------------------------------------------------------------
// Camera control frame parser engine
// Buffers frame bytes, checks length and CRC one byte per cycle, rescans after
// errors one byte per cycle and drives the registered result item.
// ----------------------------------------------------------------------------
module ccfp_back
  import ccfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IW = $clog2(MAX_FRAME_BYTES);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [15:0]   frames, frames_next;
  logic [15:0]   crcerrs, crcerrs_next;
  logic [15:0]   resyncs, resyncs_next;
  logic [IW-1:0] idx, idx_next;
  logic [7:0]    crc, crc_next;
  event_t        ev, ev_next;
  logic [2:0]    ridx, ridx_next;
  logic [7:0]    rcrc, rcrc_next;
  logic          ov, ov_next;
  result_t       res_next;

  logic [7:0]    fbuf [MAX_FRAME_BYTES];
  logic          wr_en;
  logic          shift_en;
  logic          load;
  logic          out_free;
  logic [2:0]    len;
  logic [7:0]    chk_byte;
  logic [7:0]    rep_byte;
  event_t        act_ev;

  assign out_valid = ov;
  assign out_free  = !ov || !out_stall;
  assign len       = length_for(fbuf[POS_CMD]);
  assign chk_byte  = (len == LEN_SHORT) ? fbuf[POS_CRC_S] : fbuf[POS_CRC_L];

  always_comb begin
    unique case (fbuf[POS_ACTION])
      ACT_TOGGLE: act_ev = EV_TOGGLE;
      ACT_START:  act_ev = EV_START;
      ACT_STOP:   act_ev = EV_STOP;
      default:    act_ev = EV_NONE;
    endcase
  end

  always_comb begin
    case (ridx)
      3'd0:    rep_byte = SYNC_BYTE;
      3'd1:    rep_byte = cfg.protocol_version;
      3'd2:    rep_byte = cfg.feature_bits[7:0];
      3'd3:    rep_byte = cfg.feature_bits[15:8];
      default: rep_byte = rcrc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    count_next   = count;
    frames_next  = frames;
    crcerrs_next = crcerrs;
    resyncs_next = resyncs;
    idx_next     = idx;
    crc_next     = crc;
    ev_next      = ev;
    ridx_next    = ridx;
    rcrc_next    = rcrc;
    res_next     = res;
    state_next   = state;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    shift_en     = 1'b0;
    load         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          ev_next    = EV_NONE;
          state_next = ST_EMIT;
          if (q_item.op == OP_IDLE) begin
            if (count != '0) begin
              count_next   = '0;
              resyncs_next = resyncs + 16'd1;
            end
          end else if (count == '0) begin
            if (q_item.is_sync) begin
              wr_en      = 1'b1;
              count_next = CW'(1);
            end
          end else begin
            if (count < CW'(MAX_FRAME_BYTES)) begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (count < CW'(2)) begin
          state_next = ST_EMIT;
        end else if (len == LEN_NONE) begin
          state_next = ST_DROP;
        end else if (count < CW'(len)) begin
          state_next = ST_EMIT;
        end else begin
          idx_next   = '0;
          crc_next   = 8'h00;
          state_next = ST_CRC;
        end
      end
      ST_CRC: begin
        crc_next = crc_update(crc, fbuf[idx]);
        idx_next = idx + IW'(1);
        if (LEN_W'(idx) == len - LEN_W'(2)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (crc != chk_byte) begin
          crcerrs_next = crcerrs + 16'd1;
          state_next   = ST_DROP;
        end else begin
          frames_next = frames + 16'd1;
          count_next  = '0;
          if (fbuf[POS_CMD] == CMD_DEVICE_INFO && cfg.reply_enable) begin
            ridx_next  = 3'd0;
            rcrc_next  = 8'h00;
            state_next = ST_REPLY;
          end else begin
            ev_next    = (fbuf[POS_CMD] == CMD_CAMERA) ? act_ev : EV_NONE;
            state_next = ST_EMIT;
          end
        end
      end
      ST_DROP: begin
        shift_en     = 1'b1;
        count_next   = count - CW'(1);
        resyncs_next = resyncs + 16'd1;
        state_next   = ST_SEEK;
      end
      ST_SEEK: begin
        if (count != '0 && fbuf[0] != SYNC_BYTE) begin
          shift_en   = 1'b1;
          count_next = count - CW'(1);
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load                     = 1'b1;
          res_next.event_res       = ev;
          res_next.reply_valid     = 1'b0;
          res_next.reply_byte      = 8'h00;
          res_next.last            = 1'b1;
          res_next.frame_count     = frames;
          res_next.crc_error_count = crcerrs;
          res_next.resync_count    = resyncs;
          state_next               = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          load                     = 1'b1;
          res_next.event_res       = EV_NONE;
          res_next.reply_valid     = 1'b1;
          res_next.reply_byte      = rep_byte;
          res_next.last            = (ridx == REPLY_LAST);
          res_next.frame_count     = frames;
          res_next.crc_error_count = crcerrs;
          res_next.resync_count    = resyncs;
          rcrc_next                = crc_update(rcrc, rep_byte);
          ridx_next                = ridx + 3'd1;
          if (ridx == REPLY_LAST) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ov_next = load || (ov && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      frames  <= 16'd0;
      crcerrs <= 16'd0;
      resyncs <= 16'd0;
      ov      <= 1'b0;
    end else begin
      count   <= count_next;
      frames  <= frames_next;
      crcerrs <= crcerrs_next;
      resyncs <= resyncs_next;
      ov      <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    crc  <= crc_next;
    ev   <= ev_next;
    ridx <= ridx_next;
    rcrc <= rcrc_next;
    res  <= res_next;
  end

  // Frame buffer: append at the fill position, or shift down by one byte.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < MAX_FRAME_BYTES - 1; i++) begin
        fbuf[i] <= fbuf[i+1];
      end
    end else if (wr_en) begin
      fbuf[count[IW-1:0]] <= q_item.data;
    end
  end

endmodule

// ===== hdl/camera_control_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// Camera control frame parser
// Frames camera-control requests from a received byte stream. Each input item
// is either a received byte (mode 0) or a line-idle event (mode 1). Requests
// start with header 0xCC, are three or four bytes long according to their
// command byte and end in a CRC8 over all earlier bytes. Every input item
// yields one result item, except a device info request with replies enabled,
// which yields the five reply bytes as five result items, the last marked.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready and should only be written while the block idles.
// Items pass a two-entry queue, so the front end keeps accepting while a
// result waits. Idle events, noise and a first header take the shortest
// path through the engine; a byte that completes a frame also runs the CRC
// check, and a resync drops bytes and rescans before it goes on. The engine
// handles one item at a time. Results come from an output register that
// holds steady while out_stall is high. Reset empties the queue and the frame
// buffer count, clears all counters and restores the register defaults.
// ----------------------------------------------------------------------------
module camera_control_frame_parser_core
  import ccfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic        reply_valid,
  output logic [7:0]  reply_byte,
  output logic        last,
  output logic [15:0] frame_count,
  output logic [15:0] crc_error_count,
  output logic [15:0] resync_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= VERSION_RESET;
      cfg.feature_bits     <= FEATURE_RESET;
      cfg.reply_enable     <= REPLY_ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROTOCOL_VERSION: cfg.protocol_version <= cfg_data[7:0];
        REG_FEATURE_BITS:     cfg.feature_bits     <= cfg_data;
        REG_REPLY_ENABLE:     cfg.reply_enable     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classifies each accepted item and queues it.
  ccfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Frame engine: buffering, CRC checking, resync and result generation.
  ccfp_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign event_res       = res.event_res;
  assign reply_valid     = res.reply_valid;
  assign reply_byte      = res.reply_byte;
  assign last            = res.last;
  assign frame_count     = res.frame_count;
  assign crc_error_count = res.crc_error_count;
  assign resync_count    = res.resync_count;

endmodule

// ===== hdl/ccfp_checker.sv =====
// ----------------------------------------------------------------------------
// Camera control frame parser checker
// Watches the result channel of the top level for reply framing, counter
// steps and a steady payload under stall.
// ----------------------------------------------------------------------------
module ccfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_res,
  input logic        reply_valid,
  input logic [7:0]  reply_byte,
  input logic        last,
  input logic [15:0] frame_count
);

  logic        fc_seen;
  logic [15:0] fc_prev;
  logic        in_rep;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fc_seen <= 1'b0;
      in_rep  <= 1'b0;
    end else if (out_take) begin
      fc_seen <= 1'b1;
      in_rep  <= reply_valid && !last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      fc_prev <= frame_count;
    end
  end

  // A plain result carries no reply byte and always closes its item.
  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply_valid |-> reply_byte == 8'h00 && last)
    else $error("plain result with reply byte or without last");

  // Once a reply has started, its remaining bytes follow without events.
  a_reply_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_rep |-> reply_valid && event_res == 2'd0)
    else $error("reply interrupted or carrying an event");

  // One input item dispatches at most one frame.
  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    out_take && fc_seen |-> frame_count == fc_prev || frame_count == fc_prev + 16'd1)
    else $error("frame count stepped by more than one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_byte) && $stable(frame_count)
      && $stable(last))
    else $error("stalled result changed");

endmodule

bind camera_control_frame_parser_core ccfp_checker u_checker (.*);
